// ----- sv/mdaa_pkg.sv -----
// Shared types and mode codes for the multiply, divide and ASCII adjust unit.
package mdaa_pkg;

	localparam logic [3:0] MODE_MUL8   = 4'd0;
	localparam logic [3:0] MODE_MUL16  = 4'd1;
	localparam logic [3:0] MODE_IMUL8  = 4'd2;
	localparam logic [3:0] MODE_IMUL16 = 4'd3;
	localparam logic [3:0] MODE_DIV8   = 4'd4;
	localparam logic [3:0] MODE_DIV16  = 4'd5;
	localparam logic [3:0] MODE_IDIV8  = 4'd6;
	localparam logic [3:0] MODE_IDIV16 = 4'd7;
	localparam logic [3:0] MODE_AAM    = 4'd8;
	localparam logic [3:0] MODE_AAD    = 4'd9;

	// Quotient bits resolved per divider stage, and the stage count.
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = 16 / DIV_STEPS;

	typedef struct packed {
		logic [3:0]         mode;
		logic [15:0]        ax;
		logic [15:0]        dx;
		logic signed [16:0] ma;
		logic signed [16:0] mb;
		logic [31:0]        prod;
		logic [15:0]        rem;
		logic [15:0]        low;
		logic [15:0]        quo;
		logic [15:0]        dvs;
		logic               qneg;
		logic               rneg;
		logic               ovf;
	} pipe_t;

	typedef struct packed {
		logic [15:0] ax_out;
		logic [15:0] dx_out;
		logic        carry_flag;
		logic        overflow_flag;
		logic        carry_overflow_written;
		logic        zero_flag;
		logic        sign_flag;
		logic        parity_flag;
		logic        divide_fault;
	} res_t;

endpackage

// ----- sv/mdaa_decode.sv -----
// Decode stage: operand magnitudes, signs, range precheck and multiplier operands.
module mdaa_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [3:0]      mode,
	input  logic [15:0]     ax_in,
	input  logic [15:0]     dx_in,
	input  logic [15:0]     source_value,
	output logic            valid_s1,
	output mdaa_pkg::pipe_t pipe_s1
);

	logic [7:0]      al, ah, s8;
	logic [31:0]     n, na;
	logic [15:0]     d, da;
	logic            sgn, nneg, dneg;
	mdaa_pkg::pipe_t nxt;

	assign al = ax_in[7:0];
	assign ah = ax_in[15:8];
	assign s8 = source_value[7:0];

	always_comb begin
		n   = '0;
		d   = '0;
		sgn = 1'b0;
		unique case (mode)
			mdaa_pkg::MODE_DIV8: begin
				n = {16'd0, ax_in};
				d = {8'd0, s8};
			end
			mdaa_pkg::MODE_DIV16: begin
				n = {dx_in, ax_in};
				d = source_value;
			end
			mdaa_pkg::MODE_IDIV8: begin
				n   = {{16{ax_in[15]}}, ax_in};
				d   = {{8{s8[7]}}, s8};
				sgn = 1'b1;
			end
			mdaa_pkg::MODE_IDIV16: begin
				n   = {dx_in, ax_in};
				d   = source_value;
				sgn = 1'b1;
			end
			mdaa_pkg::MODE_AAM: begin
				n = {24'd0, al};
				d = {8'd0, s8};
			end
			default: begin
				n = '0;
				d = '0;
			end
		endcase
		nneg = sgn & n[31];
		dneg = sgn & d[15];
		na   = nneg ? (~n + 32'd1) : n;
		da   = dneg ? (~d + 16'd1) : d;

		nxt      = '0;
		nxt.mode = mode;
		nxt.ax   = ax_in;
		nxt.dx   = dx_in;
		unique case (mode)
			mdaa_pkg::MODE_MUL8: begin
				nxt.ma = {9'd0, al};
				nxt.mb = {9'd0, s8};
			end
			mdaa_pkg::MODE_MUL16: begin
				nxt.ma = {1'b0, ax_in};
				nxt.mb = {1'b0, source_value};
			end
			mdaa_pkg::MODE_IMUL8: begin
				nxt.ma = {{9{al[7]}}, al};
				nxt.mb = {{9{s8[7]}}, s8};
			end
			mdaa_pkg::MODE_IMUL16: begin
				nxt.ma = {ax_in[15], ax_in};
				nxt.mb = {source_value[15], source_value};
			end
			mdaa_pkg::MODE_AAD: begin
				nxt.ma = {9'd0, ah};
				nxt.mb = {9'd0, s8};
			end
			default: begin
				nxt.ma = '0;
				nxt.mb = '0;
			end
		endcase
		nxt.rem  = na[31:16];
		nxt.low  = na[15:0];
		nxt.dvs  = da;
		nxt.qneg = nneg ^ dneg;
		nxt.rneg = nneg;
		// High half at or above the divisor: quotient too wide, or divisor zero.
		nxt.ovf  = na[31:16] >= da;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s1 <= nxt;
		end
	end

endmodule

// ----- sv/mdaa_mul.sv -----
// Multiply stage: one 17x17 signed product per transaction.
module mdaa_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  mdaa_pkg::pipe_t pipe_in,
	output logic            valid_s2,
	output mdaa_pkg::pipe_t pipe_s2
);

	logic signed [33:0] full;
	mdaa_pkg::pipe_t    nxt;

	always_comb begin
		full     = pipe_in.ma * pipe_in.mb;
		nxt      = pipe_in;
		nxt.prod = full[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s2 <= nxt;
		end
	end

endmodule

// ----- sv/mdaa_div_stage.sv -----
// Divider stage: a few restoring quotient steps on the magnitudes.
module mdaa_div_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  mdaa_pkg::pipe_t pipe_in,
	output logic            valid_sd,
	output mdaa_pkg::pipe_t pipe_sd
);

	logic [16:0]     t;
	logic [15:0]     rem, low, quo;
	mdaa_pkg::pipe_t nxt;

	always_comb begin
		rem = pipe_in.rem;
		low = pipe_in.low;
		quo = pipe_in.quo;
		t   = '0;
		for (int i = 0; i < mdaa_pkg::DIV_STEPS; i++) begin
			t   = {rem, low[15]};
			low = {low[14:0], 1'b0};
			if (t >= {1'b0, pipe_in.dvs}) begin
				rem = 16'(t - {1'b0, pipe_in.dvs});
				quo = {quo[14:0], 1'b1};
			end else begin
				rem = t[15:0];
				quo = {quo[14:0], 1'b0};
			end
		end
		nxt     = pipe_in;
		nxt.rem = rem;
		nxt.low = low;
		nxt.quo = quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd <= 1'b0;
		end else if (en) begin
			valid_sd <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_sd <= nxt;
		end
	end

endmodule

// ----- sv/mdaa_finalize.sv -----
// Final stage: sign fix-up, range faults, result selection and flags.
module mdaa_finalize (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  mdaa_pkg::pipe_t pipe_in,
	output logic            valid_sf,
	output mdaa_pkg::res_t  res_sf
);

	logic [15:0]    qs, rs, q, r;
	logic [31:0]    p;
	logic [7:0]     aad_sum;
	logic           fault;
	mdaa_pkg::res_t nxt;

	always_comb begin
		p       = pipe_in.prod;
		q       = pipe_in.quo;
		r       = pipe_in.rem;
		qs      = pipe_in.qneg ? (~q + 16'd1) : q;
		rs      = pipe_in.rneg ? (~r + 16'd1) : r;
		aad_sum = 8'(pipe_in.ax[7:0] + p[7:0]);
		fault   = 1'b0;
		nxt     = '0;
		nxt.ax_out = pipe_in.ax;
		nxt.dx_out = pipe_in.dx;
		unique case (pipe_in.mode)
			mdaa_pkg::MODE_MUL8: begin
				nxt.ax_out     = p[15:0];
				nxt.carry_flag = p[15:8] != 8'd0;
				nxt.zero_flag  = p[15:0] == 16'd0;
				nxt.sign_flag  = p[7];
			end
			mdaa_pkg::MODE_MUL16: begin
				nxt.ax_out     = p[15:0];
				nxt.dx_out     = p[31:16];
				nxt.carry_flag = p[31:16] != 16'd0;
				nxt.zero_flag  = p[15:0] == 16'd0;
				nxt.sign_flag  = p[15];
			end
			mdaa_pkg::MODE_IMUL8: begin
				nxt.ax_out     = p[15:0];
				nxt.carry_flag = p[15:8] != {8{p[7]}};
				nxt.zero_flag  = p[7:0] == 8'd0;
				nxt.sign_flag  = p[7];
			end
			mdaa_pkg::MODE_IMUL16: begin
				nxt.ax_out     = p[15:0];
				nxt.dx_out     = p[31:16];
				nxt.carry_flag = p[31:16] != {16{p[15]}};
				nxt.zero_flag  = p[15:0] == 16'd0;
				nxt.sign_flag  = p[15];
			end
			mdaa_pkg::MODE_DIV8: begin
				fault          = pipe_in.ovf | (q[15:8] != 8'd0);
				nxt.ax_out     = {r[7:0], q[7:0]};
				nxt.zero_flag  = q[7:0] == 8'd0;
				nxt.sign_flag  = q[7];
			end
			mdaa_pkg::MODE_DIV16: begin
				fault          = pipe_in.ovf;
				nxt.ax_out     = q;
				nxt.dx_out     = r;
				nxt.zero_flag  = q == 16'd0;
				nxt.sign_flag  = q[15];
			end
			mdaa_pkg::MODE_IDIV8: begin
				fault          = pipe_in.ovf | (q[15:7] != 9'd0);
				nxt.ax_out     = {rs[7:0], qs[7:0]};
				nxt.zero_flag  = qs[7:0] == 8'd0;
				nxt.sign_flag  = qs[7];
			end
			mdaa_pkg::MODE_IDIV16: begin
				fault          = pipe_in.ovf | q[15];
				nxt.ax_out     = qs;
				nxt.dx_out     = rs;
				nxt.zero_flag  = qs == 16'd0;
				nxt.sign_flag  = qs[15];
			end
			mdaa_pkg::MODE_AAM: begin
				fault          = pipe_in.ovf;
				nxt.ax_out     = {q[7:0], r[7:0]};
				nxt.zero_flag  = r[7:0] == 8'd0;
				nxt.sign_flag  = r[7];
			end
			mdaa_pkg::MODE_AAD: begin
				nxt.ax_out     = {8'd0, aad_sum};
				nxt.zero_flag  = aad_sum == 8'd0;
				nxt.sign_flag  = aad_sum[7];
			end
			default: begin
				nxt.ax_out = pipe_in.ax;
			end
		endcase
		nxt.overflow_flag = nxt.carry_flag;
		nxt.carry_overflow_written = (pipe_in.mode <= mdaa_pkg::MODE_IMUL16)
			|| (pipe_in.mode == mdaa_pkg::MODE_AAM) || (pipe_in.mode == mdaa_pkg::MODE_AAD);
		nxt.parity_flag = (pipe_in.mode <= mdaa_pkg::MODE_AAD) ? ~^nxt.ax_out[7:0] : 1'b0;
		if (pipe_in.mode == mdaa_pkg::MODE_AAM) begin
			nxt.parity_flag = ~^r[7:0];
		end
		if (fault) begin
			nxt              = '0;
			nxt.ax_out       = pipe_in.ax;
			nxt.dx_out       = pipe_in.dx;
			nxt.divide_fault = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sf <= 1'b0;
		end else if (en) begin
			valid_sf <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_sf <= nxt;
		end
	end

endmodule

// ----- sv/multiply_divide_ascii_adjust_unit.sv -----
// Top level of the multiply, divide and ASCII adjust unit.
// Takes one instruction transaction per cycle and returns one result transaction
// for each, in order, after it passes through one decode stage, one multiply
// stage, eight divider stages that each resolve two quotient bits of the 32/16
// restoring divide, and a final stage that is also the output register. The
// whole pipeline advances together; when the output is held by m_tready low,
// every stage holds and s_tready drops, so throughput is one transaction per
// cycle whenever the downstream side takes results every cycle.
module multiply_divide_ascii_adjust_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[3:0], ax_in[19:4], dx_in[35:20], source_value[51:36], zero pad
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// ax_out[15:0], dx_out[31:16], carry_flag[32], overflow_flag[33],
	// carry_overflow_written[34], zero_flag[35], sign_flag[36], parity_flag[37],
	// divide_fault[38], zero pad
	output logic [39:0] m_tdata
);

	logic                en;
	logic                valid_s1, valid_s2;
	mdaa_pkg::pipe_t     pipe_s1, pipe_s2;
	logic                div_valid [mdaa_pkg::DIV_STAGES+1];
	mdaa_pkg::pipe_t     div_pipe  [mdaa_pkg::DIV_STAGES+1];
	mdaa_pkg::res_t      res;

	// Advance everything unless a finished result is waiting.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	mdaa_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_tvalid),
		.mode         (s_tdata[3:0]),
		.ax_in        (s_tdata[19:4]),
		.dx_in        (s_tdata[35:20]),
		.source_value (s_tdata[51:36]),
		.valid_s1     (valid_s1),
		.pipe_s1      (pipe_s1)
	);

	mdaa_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s1),
		.pipe_in  (pipe_s1),
		.valid_s2 (valid_s2),
		.pipe_s2  (pipe_s2)
	);

	assign div_valid[0] = valid_s2;
	assign div_pipe[0]  = pipe_s2;

	// Divider chain: each stage shifts in the next dividend bits.
	for (genvar g = 0; g < mdaa_pkg::DIV_STAGES; g++) begin : g_div
		mdaa_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (div_valid[g]),
			.pipe_in  (div_pipe[g]),
			.valid_sd (div_valid[g+1]),
			.pipe_sd  (div_pipe[g+1])
		);
	end

	mdaa_finalize u_finalize (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (div_valid[mdaa_pkg::DIV_STAGES]),
		.pipe_in  (div_pipe[mdaa_pkg::DIV_STAGES]),
		.valid_sf (m_tvalid),
		.res_sf   (res)
	);

	assign m_tdata = {1'b0, res.divide_fault, res.parity_flag, res.sign_flag,
		res.zero_flag, res.carry_overflow_written, res.overflow_flag,
		res.carry_flag, res.dx_out, res.ax_out};

	// A faulting transaction must report no flags at all.
	a_fault_clears_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.divide_fault) |-> (m_tdata[37:32] == 6'd0))
		else $error("fault result carries flags");

	// CF and OF always agree in this unit.
	a_cf_of_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.carry_flag == res.overflow_flag))
		else $error("CF and OF differ");

	// A held output stalls the whole pipeline.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while output stalled");

endmodule

// ----- verif/multiply_divide_ascii_adjust_unit_tb.sv -----
// Testbench for the multiply, divide and ASCII adjust unit: directed and random instructions.
module multiply_divide_ascii_adjust_unit_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic [15:0] ax_out;
		logic [15:0] dx_out;
		logic        cf;
		logic        of;
		logic        cow;
		logic        zf;
		logic        sf;
		logic        pf;
		logic        fault;
	} alu_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	alu_result_t pending_results[$];
	int          error_count;
	int          idle_cycles;
	bit          pressure_on;

	multiply_divide_ascii_adjust_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic even_ones(input logic [7:0] b);
		return ~^b;
	endfunction

	// Work out the new AX, DX and flags for one instruction.
	function automatic alu_result_t compute_result(input logic [3:0] mode,
			input logic [15:0] ax, input logic [15:0] dx, input logic [15:0] src);
		alu_result_t  r;
		logic [31:0]  p;
		logic [31:0]  dividend;
		logic [31:0]  q;
		logic [31:0]  rm;
		longint       sn;
		longint       sd;
		longint       sq;
		longint       sr;
		logic [7:0]   low;
		bit           fault;
		r = '0;
		r.ax_out = ax;
		r.dx_out = dx;
		fault = 1'b0;
		low = '0;
		case (mode)
			mdaa_pkg::MODE_MUL8: begin
				p = ax[7:0] * src[7:0];
				r.ax_out = p[15:0];
				r.cf = p[15:8] != 0;
				r.cow = 1'b1;
				r.zf = p[15:0] == 0;
				r.sf = p[7];
				low = p[7:0];
			end
			mdaa_pkg::MODE_MUL16: begin
				p = ax * src;
				r.ax_out = p[15:0];
				r.dx_out = p[31:16];
				r.cf = p[31:16] != 0;
				r.cow = 1'b1;
				r.zf = p[15:0] == 0;
				r.sf = p[15];
				low = p[7:0];
			end
			mdaa_pkg::MODE_IMUL8: begin
				p = 32'($signed(ax[7:0]) * $signed(src[7:0]));
				r.ax_out = p[15:0];
				r.cf = p[15:8] != {8{p[7]}};
				r.cow = 1'b1;
				r.zf = p[7:0] == 0;
				r.sf = p[7];
				low = p[7:0];
			end
			mdaa_pkg::MODE_IMUL16: begin
				p = 32'($signed(ax) * $signed(src));
				r.ax_out = p[15:0];
				r.dx_out = p[31:16];
				r.cf = p[31:16] != {16{p[15]}};
				r.cow = 1'b1;
				r.zf = p[15:0] == 0;
				r.sf = p[15];
				low = p[7:0];
			end
			mdaa_pkg::MODE_DIV8: begin
				if (src[7:0] == 0 || ax / src[7:0] > 32'hFF) begin
					fault = 1'b1;
				end else begin
					q = ax / src[7:0];
					rm = ax % src[7:0];
					r.ax_out = {rm[7:0], q[7:0]};
					r.zf = q[7:0] == 0;
					r.sf = q[7];
					low = q[7:0];
				end
			end
			mdaa_pkg::MODE_DIV16: begin
				dividend = {dx, ax};
				if (src == 0 || dividend / src > 32'hFFFF) begin
					fault = 1'b1;
				end else begin
					q = dividend / src;
					rm = dividend % src;
					r.ax_out = q[15:0];
					r.dx_out = rm[15:0];
					r.zf = q[15:0] == 0;
					r.sf = q[15];
					low = q[7:0];
				end
			end
			mdaa_pkg::MODE_IDIV8, mdaa_pkg::MODE_IDIV16: begin
				if (mode == mdaa_pkg::MODE_IDIV8) begin
					sn = longint'($signed(ax));
					sd = longint'($signed(src[7:0]));
				end else begin
					sn = longint'($signed({dx, ax}));
					sd = longint'($signed(src));
				end
				if (sd == 0) begin
					fault = 1'b1;
				end else begin
					sq = sn / sd;
					sr = sn % sd;
					if ((mode == mdaa_pkg::MODE_IDIV8 && (sq > 127 || sq < -127)) ||
							(mode == mdaa_pkg::MODE_IDIV16 &&
							(sq > 32767 || sq < -32767))) begin
						fault = 1'b1;
					end else if (mode == mdaa_pkg::MODE_IDIV8) begin
						r.ax_out = {sr[7:0], sq[7:0]};
						r.zf = sq[7:0] == 0;
						r.sf = sq[7];
						low = sq[7:0];
					end else begin
						r.ax_out = sq[15:0];
						r.dx_out = sr[15:0];
						r.zf = sq[15:0] == 0;
						r.sf = sq[15];
						low = sq[7:0];
					end
				end
			end
			mdaa_pkg::MODE_AAM: begin
				if (src[7:0] == 0) begin
					fault = 1'b1;
				end else begin
					q = ax[7:0] % src[7:0];
					rm = ax[7:0] / src[7:0];
					r.ax_out = {rm[7:0], q[7:0]};
					r.cow = 1'b1;
					r.zf = q[7:0] == 0;
					r.sf = q[7];
					low = q[7:0];
				end
			end
			mdaa_pkg::MODE_AAD: begin
				q = ax[7:0] + ax[15:8] * src[7:0];
				r.ax_out = {8'h00, q[7:0]};
				r.cow = 1'b1;
				r.zf = q[7:0] == 0;
				r.sf = q[7];
				low = q[7:0];
			end
			default: begin
				return r;
			end
		endcase
		r.of = r.cf;
		r.pf = even_ones(low);
		if (fault) begin
			r = '0;
			r.ax_out = ax;
			r.dx_out = dx;
			r.fault = 1'b1;
		end
		return r;
	endfunction

	// Send one instruction, with an optional random gap ahead of it.
	task automatic send_instruction(input logic [3:0] mode, input logic [15:0] ax,
			input logic [15:0] dx, input logic [15:0] src);
		if (pressure_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'h0, src, dx, ax, mode};
		pending_results.push_back(compute_result(mode, ax, dx, src));
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic test_multiply_extremes();
		send_instruction(mdaa_pkg::MODE_MUL8, 16'h00FF, 16'h1234, 16'h00FF);
		send_instruction(mdaa_pkg::MODE_MUL8, 16'h0000, 16'h0000, 16'hFF00);
		send_instruction(mdaa_pkg::MODE_MUL16, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_instruction(mdaa_pkg::MODE_MUL16, 16'h0002, 16'hFFFF, 16'h0003);
		send_instruction(mdaa_pkg::MODE_IMUL8, 16'h0080, 16'h0000, 16'h0080);
		send_instruction(mdaa_pkg::MODE_IMUL8, 16'h00FF, 16'h0000, 16'h0001);
		send_instruction(mdaa_pkg::MODE_IMUL16, 16'h8000, 16'h0000, 16'h8000);
		send_instruction(mdaa_pkg::MODE_IMUL16, 16'hFFFF, 16'h0000, 16'h0007);
	endtask

	task automatic test_divide_cases();
		// zero divisor
		send_instruction(mdaa_pkg::MODE_DIV8, 16'h1234, 16'h0000, 16'h0000);
		// quotient too big
		send_instruction(mdaa_pkg::MODE_DIV8, 16'hFFFF, 16'h0000, 16'h00FF);
		send_instruction(mdaa_pkg::MODE_DIV8, 16'h00FE, 16'h0000, 16'h0010);
		send_instruction(mdaa_pkg::MODE_DIV16, 16'hFFFF, 16'hFFFE, 16'hFFFF);
		// quotient too big
		send_instruction(mdaa_pkg::MODE_DIV16, 16'h0000, 16'h0001, 16'h0001);
		// quotient -127
		send_instruction(mdaa_pkg::MODE_IDIV8, 16'hFF81, 16'h0000, 16'h0001);
		// -128 faults
		send_instruction(mdaa_pkg::MODE_IDIV8, 16'hFF80, 16'h0000, 16'h0001);
		// negative remainder
		send_instruction(mdaa_pkg::MODE_IDIV8, 16'hFFF9, 16'h0000, 16'h0002);
		send_instruction(mdaa_pkg::MODE_IDIV16, 16'h8001, 16'hFFFF, 16'h0001);
		send_instruction(mdaa_pkg::MODE_IDIV16, 16'h0000, 16'h8000, 16'hFFFF);
		send_instruction(mdaa_pkg::MODE_IDIV16, 16'h1234, 16'h0000, 16'h0000);
	endtask

	task automatic test_adjust_and_unused();
		send_instruction(mdaa_pkg::MODE_AAM, 16'h00FF, 16'h0000, 16'h000A);
		send_instruction(mdaa_pkg::MODE_AAM, 16'h0042, 16'h0000, 16'h0000);
		send_instruction(mdaa_pkg::MODE_AAD, 16'hFFFF, 16'h0000, 16'h00FF);
		send_instruction(mdaa_pkg::MODE_AAD, 16'h0909, 16'h0000, 16'h000A);
		send_instruction(4'hA, 16'hAAAA, 16'h5555, 16'hFFFF);
		send_instruction(4'hF, 16'h5555, 16'hAAAA, 16'h0000);
	endtask

	task automatic test_random_instructions(input int count);
		logic [3:0]  mode;
		logic [15:0] ax;
		logic [15:0] dx;
		logic [15:0] src;
		for (int i = 0; i < count; i++) begin
			mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
			ax  = 16'($urandom());
			dx  = 16'($urandom());
			src = 16'($urandom());
			// Keep most divides in range: shrink the high dividend part.
			if (mode inside {mdaa_pkg::MODE_DIV16, mdaa_pkg::MODE_IDIV16} &&
					$urandom_range(0, 3) != 0)
				dx = (mode == mdaa_pkg::MODE_DIV16) ? dx % (src | 16'h1)
					: {{9{dx[15]}}, dx[6:0]};
			if (mode inside {mdaa_pkg::MODE_DIV8, mdaa_pkg::MODE_IDIV8} &&
					$urandom_range(0, 3) != 0)
				ax[15:8] = (mode == mdaa_pkg::MODE_DIV8) ? ax[15:8] % (src[7:0] | 8'h1)
					: {{2{ax[15]}}, ax[13:8] & 6'h1F};
			if ($urandom_range(0, 15) == 0)
				src = 16'h0000;
			send_instruction(mode, ax, dx, src);
		end
	endtask

	// Drive m_tready with random stall bursts while pressure is on.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		alu_result_t got;
		alu_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ax_out = m_tdata[15:0];
			got.dx_out = m_tdata[31:16];
			got.cf     = m_tdata[32];
			got.of     = m_tdata[33];
			got.cow    = m_tdata[34];
			got.zf     = m_tdata[35];
			got.sf     = m_tdata[36];
			got.pf     = m_tdata[37];
			got.fault  = m_tdata[38];
			if (pending_results.size() == 0) begin
				$error("result with no instruction pending");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.ax_out !== want.ax_out) begin
					$error("ax_out expected %h got %h", want.ax_out, got.ax_out);
					error_count++;
				end
				if (got.dx_out !== want.dx_out) begin
					$error("dx_out expected %h got %h", want.dx_out, got.dx_out);
					error_count++;
				end
				if (got.cf !== want.cf) begin
					$error("carry_flag expected %b got %b", want.cf, got.cf);
					error_count++;
				end
				if (got.of !== want.of) begin
					$error("overflow_flag expected %b got %b", want.of, got.of);
					error_count++;
				end
				if (got.cow !== want.cow) begin
					$error("carry_overflow_written expected %b got %b", want.cow, got.cow);
					error_count++;
				end
				if (got.zf !== want.zf) begin
					$error("zero_flag expected %b got %b", want.zf, got.zf);
					error_count++;
				end
				if (got.sf !== want.sf) begin
					$error("sign_flag expected %b got %b", want.sf, got.sf);
					error_count++;
				end
				if (got.pf !== want.pf) begin
					$error("parity_flag expected %b got %b", want.pf, got.pf);
					error_count++;
				end
				if (got.fault !== want.fault) begin
					$error("divide_fault expected %b got %b", want.fault, got.fault);
					error_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		idle_cycles = 0;
		pressure_on = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_multiply_extremes();
		pressure_on = 1'b1;
		test_divide_cases();
		test_adjust_and_unused();
		test_random_instructions(650);
		pressure_on = 1'b0;
		test_random_instructions(150);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
